>>> src/gcd_lcm_solution_counter_macros.svh
// Assertion macros shared by the gcd/lcm solution counter RTL.
`ifndef GCD_LCM_SOLUTION_COUNTER_MACROS_SVH
`define GCD_LCM_SOLUTION_COUNTER_MACROS_SVH

// Same-cycle implication.
`define GLSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glsc assertion failed");

// Next-cycle implication.
`define GLSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glsc assertion failed");

`endif

>>> src/gcdlcm_pkg.sv
// Shared constants and lane command type for the gcd/lcm solution counter.
package gcdlcm_pkg;

   localparam int VALUE_WIDTH_DEF = 31;
   localparam int COUNT_WIDTH_DEF = 11;
   localparam int LANES           = 4;

   typedef struct packed {
      logic load;
      logic round;
      logic mark;
   } lane_cmd_type;

endpackage

>>> src/gcd_lcm_solution_counter.sv
// Counts x with gcd(x,a0)=a1 and lcm(x,b0)=b1 by joint trial division over four lanes.
//
// One item at a time. After the item is taken, the four operands are factored
// together by rising trial divisors d while d*d does not exceed some remainder.
// For each d every lane runs a bit-serial restoring divider, once more each
// time d divides evenly. Each leftover prime is then marked in the lanes and
// folded into the count. The worst case at 31-bit operands is set by the lane
// dividers over about 46341 trial divisors. The result waits in an output
// register; a zero operand gives a count of 0.
module gcd_lcm_solution_counter import gcdlcm_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_gcd_operand,
   input  logic [VALUE_WIDTH-1:0] req_gcd_result,
   input  logic [VALUE_WIDTH-1:0] req_lcm_operand,
   input  logic [VALUE_WIDTH-1:0] req_lcm_result,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COUNT_WIDTH-1:0] rsp_solution_count
);

`include "gcd_lcm_solution_counter_macros.svh"

   localparam int VW = VALUE_WIDTH;
   localparam int DW = VALUE_WIDTH / 2 + 2;
   localparam int SW = 2 * DW;
   localparam int EW = $clog2(VALUE_WIDTH + 1);
   localparam int CW = COUNT_WIDTH;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_WAIT   = 3'd2;
   localparam logic [2:0] S_LEFT   = 3'd3;
   localparam logic [2:0] S_LFOLD  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [DW-1:0] d_ff, d_in;
   logic [SW-1:0] sq_ff, sq_in;
   logic [1:0]    idx_ff, idx_in;
   logic          zero_ff, zero_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] count_ff, count_in;

   lane_cmd_type  cmd;
   logic [VW-1:0] lane_value [LANES];
   logic [VW-1:0] req_value  [LANES];
   logic [VW-1:0] lane_rem   [LANES];
   logic [EW-1:0] lane_exp   [LANES];
   logic [LANES-1:0] lane_busy;
   logic          in_range;
   logic          hit;
   logic          any_zero;
   logic          merge_init;
   logic          merge_fold;
   logic [CW-1:0] product;
   logic [VW-1:0] p;

   assign req_value[0] = req_gcd_operand;
   assign req_value[1] = req_gcd_result;
   assign req_value[2] = req_lcm_operand;
   assign req_value[3] = req_lcm_result;

   assign req_ready = state_ff == S_IDLE;
   assign p         = lane_rem[idx_ff];

   always_comb begin
      in_range = 1'b0;
      hit      = 1'b0;
      any_zero = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         in_range = in_range | (SW'(lane_rem[i]) >= sq_ff);
         hit      = hit | (lane_exp[i] != '0);
         any_zero = any_zero | (req_value[i] == '0);
         lane_value[i] = (state_ff == S_IDLE) ? req_value[i] : p;
      end
   end

   generate
      for (genvar g = 0; g < LANES; g++) begin : g_lane
         gcdlcm_lane #(.VW(VW), .DW(DW), .EW(EW)) u_lane (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .value     (lane_value[g]),
            .divisor   (d_ff),
            .busy      (lane_busy[g]),
            .remainder (lane_rem[g]),
            .exponent  (lane_exp[g])
         );
      end
   endgenerate

   gcdlcm_merge #(.EW(EW), .CW(CW)) u_merge (
      .clock   (clock),
      .init    (merge_init),
      .fold    (merge_fold),
      .exps    (lane_exp),
      .product (product)
   );

   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      idx_in       = idx_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      count_in     = count_ff;
      cmd          = '0;
      merge_init   = 1'b0;
      merge_fold   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               merge_init = 1'b1;
               d_in       = DW'(2);
               sq_in      = SW'(4);
               zero_in    = any_zero;
               state_in   = any_zero ? S_FINISH : S_CHECK;
            end
         end
         S_CHECK: begin
            if (in_range) begin
               cmd.round = 1'b1;
               state_in  = S_WAIT;
            end else begin
               idx_in   = '0;
               state_in = S_LEFT;
            end
         end
         S_WAIT: begin
            if (lane_busy == '0) begin
               merge_fold = hit;
               d_in       = d_ff + DW'(1);
               sq_in      = sq_ff + SW'({d_ff, 1'b1});
               state_in   = S_CHECK;
            end
         end
         S_LEFT: begin
            if (p > VW'(1)) begin
               cmd.mark = 1'b1;
               state_in = S_LFOLD;
            end else if (idx_ff == 2'(LANES - 1)) begin
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         S_LFOLD: begin
            merge_fold = 1'b1;
            if (idx_ff == 2'(LANES - 1)) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_LEFT;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               count_in     = zero_ff ? '0 : product;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         d_ff         <= DW'(2);
         sq_ff        <= SW'(4);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         d_ff         <= d_in;
         sq_ff        <= sq_in;
      end
      idx_ff   <= idx_in;
      zero_ff  <= zero_in;
      count_ff <= count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_solution_count = count_ff;

   `GLSC_ASSERT_NXT(a_accept_blocks, clock, reset, req_valid && req_ready, !req_ready)
   `GLSC_ASSERT_IMP(a_square_tracks, clock, reset, 1'b1, sq_ff == SW'(d_ff) * SW'(d_ff))
   `GLSC_ASSERT_IMP(a_divisor_min, clock, reset, state_ff != S_IDLE, d_ff >= DW'(2))
   `GLSC_ASSERT_NXT(a_round_starts, clock, reset, cmd.round, lane_busy == {LANES{1'b1}})

endmodule

>>> src/gcdlcm_lane.sv
// One factoring lane: holds a remainder and runs repeated bit-serial trial divisions.
module gcdlcm_lane import gcdlcm_pkg::*; #(
   parameter int VW = VALUE_WIDTH_DEF,
   parameter int DW = VALUE_WIDTH_DEF / 2 + 2,
   parameter int EW = $clog2(VALUE_WIDTH_DEF + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  lane_cmd_type  cmd,
   input  logic [VW-1:0] value,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic [VW-1:0] remainder,
   output logic [EW-1:0] exponent
);

   localparam int CNTW = (VW > 1) ? $clog2(VW) : 1;

   logic [VW-1:0]   r_ff, r_in;
   logic [EW-1:0]   exp_ff, exp_in;
   logic            busy_ff, busy_in;
   logic [VW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   logic [DW:0]     trial;
   logic [DW:0]     diff;
   logic            ge;
   logic [DW-1:0]   rem_next;
   logic [VW-1:0]   quo_next;
   logic            last;
   logic            eq;

   always_comb begin
      trial    = {rem_ff, quo_ff[VW-1]};
      ge       = trial >= {1'b0, divisor};
      diff     = trial - {1'b0, divisor};
      rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_next = {quo_ff[VW-2:0], ge};
      last     = cnt_ff == CNTW'(VW - 1);
      eq       = r_ff == value;

      r_in    = r_ff;
      exp_in  = exp_ff;
      busy_in = busy_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;

      if (busy_ff) begin
         quo_in = quo_next;
         rem_in = rem_next;
         cnt_in = cnt_ff + CNTW'(1);
         if (last) begin
            if (rem_next == '0) begin
               // divides evenly: keep quotient, divide again
               r_in   = quo_next;
               exp_in = exp_ff + EW'(1);
               rem_in = '0;
               cnt_in = '0;
            end else begin
               busy_in = 1'b0;
            end
         end
      end else if (cmd.load) begin
         r_in   = value;
         exp_in = '0;
      end else if (cmd.round) begin
         exp_in  = '0;
         busy_in = 1'b1;
         quo_in  = r_ff;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (cmd.mark) begin
         exp_in = EW'(eq);
         if (eq) begin
            r_in = VW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      r_ff   <= r_in;
      exp_ff <= exp_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign busy      = busy_ff;
   assign remainder = r_ff;
   assign exponent  = exp_ff;

endmodule

>>> src/gcdlcm_merge.sv
// Merging stage: turns the four lane exponents into a per-prime factor and folds the product.
module gcdlcm_merge import gcdlcm_pkg::*; #(
   parameter int EW = $clog2(VALUE_WIDTH_DEF + 1),
   parameter int CW = COUNT_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          init,
   input  logic          fold,
   input  logic [EW-1:0] exps [LANES],
   output logic [CW-1:0] product
);

   localparam int FW = EW + 1;

   logic [CW-1:0]    product_ff, product_in;
   logic [FW-1:0]    factor;
   logic [CW+FW-1:0] wide;
   logic             fix_lo;
   logic             fix_hi;
   logic [EW-1:0]    ea0, ea1, eb0, eb1;

   always_comb begin
      ea0    = exps[0];
      ea1    = exps[1];
      eb0    = exps[2];
      eb1    = exps[3];
      fix_lo = ea0 > ea1;
      fix_hi = eb0 < eb1;
      if (ea0 < ea1 || eb0 > eb1) begin
         factor = '0;
      end else if (fix_lo && fix_hi) begin
         factor = FW'(ea1 == eb1);
      end else if (fix_lo || fix_hi) begin
         factor = FW'(ea1 <= eb1);
      end else if (eb1 >= ea1) begin
         factor = FW'(eb1 - ea1) + FW'(1);
      end else begin
         factor = '0;
      end
      wide = (CW+FW)'(product_ff) * (CW+FW)'(factor);

      product_in = product_ff;
      if (init) begin
         product_in = CW'(1);
      end else if (fold) begin
         // saturate at the all-ones count
         if (wide > (CW+FW)'({CW{1'b1}})) begin
            product_in = {CW{1'b1}};
         end else begin
            product_in = wide[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

>>> dv/tb_gcd_lcm_solution_counter.sv
// Self-checking testbench for the gcd/lcm solution counter.
`timescale 1ns / 100ps

module tb_gcd_lcm_solution_counter;
   import gcdlcm_pkg::*;

   localparam int VW = VALUE_WIDTH_DEF;
   localparam int CW = COUNT_WIDTH_DEF;
   localparam longint VMAX = (64'd1 << VW) - 1;
   localparam longint CMAX = (64'd1 << CW) - 1;
   localparam int RANDOM_ITEMS = 81;

   typedef struct {
      logic [VW-1:0] a0, a1, b0, b1;
      bit            typed;
      logic [CW-1:0] count;
   } beat_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [VW-1:0] req_gcd_operand = '0;
   logic [VW-1:0] req_gcd_result = '0;
   logic [VW-1:0] req_lcm_operand = '0;
   logic [VW-1:0] req_lcm_result = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [CW-1:0] rsp_solution_count;

   beat_type      stimulus[$];
   beat_type      current;
   logic [CW-1:0] pending_counts[$];
   int            errors = 0;
   int            taken = 0;
   bit            current_typed;
   logic [CW-1:0] current_count;

   gcd_lcm_solution_counter u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint prime_share(longint ea0, longint ea1, longint eb0, longint eb1);
      bit fix_lo, fix_hi;
      if (ea0 < ea1 || eb0 > eb1) return 0;
      fix_lo = ea0 > ea1;
      fix_hi = eb0 < eb1;
      if (fix_lo && fix_hi) return (ea1 == eb1) ? 1 : 0;
      if (fix_lo || fix_hi) return (ea1 <= eb1) ? 1 : 0;
      return (eb1 >= ea1) ? (eb1 - ea1 + 1) : 0;
   endfunction

   function automatic longint merge_share(longint prod, longint f);
      if (f == 0 || prod == 0) return 0;
      if (prod > CMAX / f) return CMAX;
      return prod * f;
   endfunction

   function automatic logic [CW-1:0] count_solutions(beat_type b);
      longint rem[4];
      longint ex[4];
      longint d, p, prod;
      bit     more, hit;
      rem[0] = b.a0; rem[1] = b.a1; rem[2] = b.b0; rem[3] = b.b1;
      prod = 1;
      for (int i = 0; i < 4; i++) if (rem[i] == 0) return '0;
      d = 2;
      do begin
         more = 0;
         for (int i = 0; i < 4; i++) if (d * d <= rem[i]) more = 1;
         if (more) begin
            hit = 0;
            for (int i = 0; i < 4; i++) begin
               ex[i] = 0;
               while (rem[i] % d == 0) begin
                  rem[i] /= d;
                  ex[i]++;
                  hit = 1;
               end
            end
            if (hit) prod = merge_share(prod, prime_share(ex[0], ex[1], ex[2], ex[3]));
            d++;
         end
      end while (more);
      for (int i = 0; i < 4; i++) begin
         p = rem[i];
         if (p > 1) begin
            for (int j = 0; j < 4; j++) begin
               ex[j] = (rem[j] == p) ? 1 : 0;
               if (j > i && rem[j] == p) rem[j] = 1;
            end
            rem[i] = 1;
            prod = merge_share(prod, prime_share(ex[0], ex[1], ex[2], ex[3]));
         end
      end
      return prod[CW-1:0];
   endfunction

   function automatic beat_type row(longint a0, longint a1, longint b0, longint b1,
                                    bit typed, int count);
      beat_type b;
      b.a0 = VW'(a0); b.a1 = VW'(a1); b.b0 = VW'(b0); b.b1 = VW'(b1);
      b.typed = typed;
      b.count = CW'(count);
      return b;
   endfunction

   function automatic beat_type random_beat();
      int       primes[6] = '{2, 3, 5, 7, 11, 13};
      longint   v[4];
      longint   pw[4];
      int       xe, e0, e1, kind;
      beat_type b;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         for (int i = 0; i < 4; i++) v[i] = $urandom_range(1, 65535);
      end else begin
         for (int i = 0; i < 4; i++) v[i] = 1;
         foreach (primes[k]) begin
            xe = $urandom_range(0, 4);
            e0 = $urandom_range(0, 4);
            e1 = $urandom_range(0, 4);
            for (int i = 0; i < 4; i++) pw[i] = 1;
            repeat (e0) pw[0] *= primes[k];
            repeat (xe < e0 ? xe : e0) pw[1] *= primes[k];
            repeat (e1) pw[2] *= primes[k];
            repeat (xe > e1 ? xe : e1) pw[3] *= primes[k];
            if (v[0] * pw[0] <= VMAX && v[1] * pw[1] <= VMAX &&
                v[2] * pw[2] <= VMAX && v[3] * pw[3] <= VMAX)
               for (int i = 0; i < 4; i++) v[i] *= pw[i];
         end
         if ($urandom_range(0, 3) == 0 && v[0] * 65521 <= VMAX && v[1] * 65521 <= VMAX) begin
            v[0] *= 65521;
            v[1] *= 65521;
         end
         if (kind < 4) v[$urandom_range(0, 3)] = $urandom_range(1, 4095);
      end
      b = row(v[0], v[1], v[2], v[3], 0, 0);
      return b;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            current_typed = stimulus[taken].typed;
            current_count = current_typed ? stimulus[taken].count
                                          : count_solutions(stimulus[taken]);
            if (current_typed && current_count != count_solutions(stimulus[taken])) begin
               $error("solution_count table entry disagrees with predictor: %0d vs %0d",
                      current_count, count_solutions(stimulus[taken]));
               errors++;
            end
            pending_counts.push_back(current_count);
            taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_counts.size() == 0) begin
               $error("solution_count beat with nothing expected: actual %0d",
                      rsp_solution_count);
               errors++;
            end else begin
               current_count = pending_counts.pop_front();
               if (rsp_solution_count !== current_count) begin
                  $error("solution_count mismatch: expected %0d actual %0d",
                         current_count, rsp_solution_count);
                  errors++;
               end
            end
         end
      end
   end

   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9])
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   initial begin
      int gap;
      int sent;
      int total;
      stimulus.push_back(row(1, 1, 1, 1, 1, 1));
      stimulus.push_back(row(0, 1, 1, 1, 1, 0));
      stimulus.push_back(row(1, 0, 1, 1, 1, 0));
      stimulus.push_back(row(1, 1, 0, 1, 1, 0));
      stimulus.push_back(row(1, 1, 1, 0, 1, 0));
      stimulus.push_back(row(41, 1, 96, 288, 1, 6));
      stimulus.push_back(row(95, 1, 37, 1776, 1, 2));
      stimulus.push_back(row(2147483646, 2147483646, 1, 2147483646, 1, 1));
      stimulus.push_back(row(1, 1, 1, 1073741824, 0, 0));
      stimulus.push_back(row(1073741824, 1, 1, 1073741824, 0, 0));
      stimulus.push_back(row(1073741824, 1073741824, 1073741824, 1073741824, 0, 0));
      stimulus.push_back(row(6, 4, 1, 12, 0, 0));
      stimulus.push_back(row(12, 4, 3, 36, 0, 0));
      stimulus.push_back(row(1, 1, 1, 2 * 3 * 5 * 7 * 11 * 13 * 17 * 19 * 23, 0, 0));
      stimulus.push_back(row(1, 1, 1, 720720 * 2, 0, 0));
      stimulus.push_back(row(65521 * 3, 65521, 65521, 65521 * 2, 0, 0));
      stimulus.push_back(row(8, 2, 4, 4, 0, 0));
      stimulus.push_back(row(2, 2, 2, 2, 0, 0));
      stimulus.push_back(row(1431655765, 5, 715827882, 2147483646, 0, 0));
      for (int i = 0; i < RANDOM_ITEMS; i++) stimulus.push_back(random_beat());
      total = stimulus.size();
      sent = 0;
      gap = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (sent < total) begin
         @(posedge clock);
         if (req_valid && req_ready) begin
            sent++;
            if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 20);
         end
         if (sent == total) begin
            req_valid <= 1'b0;
         end else if (sent == total / 2 && pending_counts.size() != 0) begin
            req_valid <= 1'b0;
         end else if (gap > 0 && !req_valid) begin
            gap--;
         end else if (gap > 0 && !(req_valid && !req_ready)) begin
            req_valid <= 1'b0;
            gap--;
         end else begin
            current = stimulus[sent];
            req_valid <= 1'b1;
            req_gcd_operand <= current.a0;
            req_gcd_result <= current.a1;
            req_lcm_operand <= current.b0;
            req_lcm_result <= current.b1;
         end
      end
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("gcd_lcm_solution_counter verification clean");
      else
         $display("gcd_lcm_solution_counter verification failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("gcd_lcm_solution_counter verification failed");
      $finish;
   end

endmodule
